// File: rtl/core/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes for the process ready queue
// Field widths, operation and status codes, the entry record, the RAM
// command group and the sequencer state type.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Field widths fixed by the beat format.
    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 8;
    localparam int PID_W    = 15;
    localparam int STATUS_W = 2;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND    = 3'd4;

    // Status codes reported with every result.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // One queue entry as held in the slot RAM.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
    } t_entry;

    // Strobes from the sequencer to the slot RAM.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RES,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REPLY
    } t_state;

endpackage

// File: rtl/core/prq_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_slot_ram: entry storage for the process ready queue
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module prq_slot_ram #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic              i_clk,
    input  prq_pkg::t_ram_cmd i_cmd,
    input  logic [AW-1:0]     i_wr_addr,
    input  prq_pkg::t_entry   i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output prq_pkg::t_entry   o_rd_data
);

    prq_pkg::t_entry r_mem [QUEUE_DEPTH];
    prq_pkg::t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/process_ready_queue.sv
`timescale 1ns / 1ps
// Enqueue and unused kinds go straight to the reply; dequeue and peek on a non-empty list
// first read the head slot; find reads and compares each entry in turn, and remove does the
// same and then moves each later entry down by a read and a write. One operation is in work
// at a time: a new request beat is taken only once the sequencer is back in idle, after the
// last reply has been loaded into the output register.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// process_ready_queue: bounded FIFO ready list with remove and search
// Circular buffer in a slot RAM with head pointer and entry count. A small
// sequencer walks the RAM for find and remove and closes the gap after a
// removal by moving later entries down one slot at a time.
// ----------------------------------------------------------------------------
module process_ready_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [prq_pkg::KIND_W-1:0]          i_kind,
    input  logic [prq_pkg::HANDLE_W-1:0]        i_item_handle,
    input  logic [prq_pkg::PID_W-1:0]           i_process_id,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [prq_pkg::STATUS_W-1:0]        o_status,
    output logic [prq_pkg::HANDLE_W-1:0]        o_result_handle,
    output logic [prq_pkg::PID_W-1:0]           o_result_pid,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_entry_count,
    output logic                                o_is_empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);

    // Control registers.
    prq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;

    // Operation and walk registers.
    logic [prq_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [prq_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [prq_pkg::PID_W-1:0]    r_pid, n_pid;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic [CW-1:0]                r_idx, n_idx;

    // Pending result and output registers.
    logic [prq_pkg::STATUS_W-1:0] r_status, n_status;
    prq_pkg::t_entry              r_res, n_res;
    logic [prq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    prq_pkg::t_entry              r_out_res, n_out_res;
    logic [CW-1:0]                r_out_count, n_out_count;

    // RAM connections.
    prq_pkg::t_ram_cmd ram_cmd;
    logic [AW-1:0]     ram_wr_addr;
    prq_pkg::t_entry   ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    prq_pkg::t_entry   ram_rd_data;

    logic              in_beat;
    logic              out_free;
    logic              is_full;
    logic              walk_done;
    logic              hit;
    logic [SW-1:0]     tail_sum;
    logic [AW-1:0]     tail;
    logic [AW-1:0]     ptr_next;
    prq_pkg::t_entry   in_entry;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    prq_slot_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_cmd     (ram_cmd),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshake and shared compare terms.
    assign o_in_stall = (r_state != prq_pkg::S_IDLE);
    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_full    = (r_count == FULL_CNT);
    assign walk_done  = (r_idx == r_count);
    assign ptr_next   = slot_inc(r_ptr);
    assign in_entry   = '{handle: i_item_handle, pid: i_process_id};
    assign hit        = (r_kind == prq_pkg::KIND_REMOVE)
                        ? (ram_rd_data.handle == r_handle)
                        : (ram_rd_data.pid == r_pid);

    // Tail slot: head plus count, wrapped once.
    assign tail_sum = {1'b0, r_head} + SW'(r_count);
    always_comb begin
        if (tail_sum >= DEPTH_SUM) begin
            tail = AW'(tail_sum - DEPTH_SUM);
        end else begin
            tail = tail_sum[AW-1:0];
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prq_pkg::S_IDLE: begin
                if (in_beat) begin
                    unique case (i_kind) inside
                        prq_pkg::KIND_DEQUEUE, prq_pkg::KIND_PEEK: begin
                            n_state = (r_count == '0) ? prq_pkg::S_REPLY
                                                      : prq_pkg::S_HEAD_RES;
                        end
                        prq_pkg::KIND_REMOVE, prq_pkg::KIND_FIND: begin
                            n_state = prq_pkg::S_SCAN_RD;
                        end
                        default: begin
                            n_state = prq_pkg::S_REPLY;
                        end
                    endcase
                end
            end
            prq_pkg::S_HEAD_RES: begin
                n_state = prq_pkg::S_REPLY;
            end
            prq_pkg::S_SCAN_RD: begin
                n_state = walk_done ? prq_pkg::S_REPLY : prq_pkg::S_SCAN_CMP;
            end
            prq_pkg::S_SCAN_CMP: begin
                if (!hit) begin
                    n_state = prq_pkg::S_SCAN_RD;
                end else if (r_kind == prq_pkg::KIND_REMOVE) begin
                    n_state = prq_pkg::S_SHIFT_RD;
                end else begin
                    n_state = prq_pkg::S_REPLY;
                end
            end
            prq_pkg::S_SHIFT_RD: begin
                n_state = walk_done ? prq_pkg::S_REPLY : prq_pkg::S_SHIFT_WR;
            end
            prq_pkg::S_SHIFT_WR: begin
                n_state = prq_pkg::S_SHIFT_RD;
            end
            prq_pkg::S_REPLY: begin
                n_state = out_free ? prq_pkg::S_IDLE : prq_pkg::S_REPLY;
            end
            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM strobes and result registers per state.
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_kind       = r_kind;
        n_handle     = r_handle;
        n_pid        = r_pid;
        n_ptr        = r_ptr;
        n_idx        = r_idx;
        n_status     = r_status;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_res    = r_out_res;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && i_out_stall;
        ram_cmd      = '{wr_en: 1'b0, rd_en: 1'b0};
        ram_wr_addr  = r_ptr;
        ram_wr_data  = ram_rd_data;
        ram_rd_addr  = r_ptr;

        unique case (r_state)
            prq_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_kind   = i_kind;
                    n_handle = i_item_handle;
                    n_pid    = i_process_id;
                    n_ptr    = r_head;
                    n_idx    = '0;
                    n_status = prq_pkg::ST_OK;
                    n_res    = '0;
                    unique case (i_kind) inside
                        prq_pkg::KIND_ENQUEUE: begin
                            if (is_full) begin
                                n_status = prq_pkg::ST_FULL;
                            end else begin
                                ram_cmd.wr_en = 1'b1;
                                ram_wr_addr   = tail;
                                ram_wr_data   = in_entry;
                                n_count       = r_count + CW'(1);
                            end
                        end
                        prq_pkg::KIND_DEQUEUE, prq_pkg::KIND_PEEK: begin
                            if (r_count == '0) begin
                                n_status = prq_pkg::ST_MISS;
                            end else begin
                                ram_cmd.rd_en = 1'b1;
                                ram_rd_addr   = r_head;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            prq_pkg::S_HEAD_RES: begin
                n_res = ram_rd_data;
                if (r_kind == prq_pkg::KIND_DEQUEUE) begin
                    n_head  = slot_inc(r_head);
                    n_count = r_count - CW'(1);
                end
            end
            prq_pkg::S_SCAN_RD: begin
                if (walk_done) begin
                    n_status = prq_pkg::ST_MISS;
                end else begin
                    ram_cmd.rd_en = 1'b1;
                end
            end
            prq_pkg::S_SCAN_CMP: begin
                // On a hit the pointer stays on the slot that is freed.
                n_idx = r_idx + CW'(1);
                if (!hit) begin
                    n_ptr = ptr_next;
                end else if (r_kind == prq_pkg::KIND_FIND) begin
                    n_res = ram_rd_data;
                end
            end
            prq_pkg::S_SHIFT_RD: begin
                if (walk_done) begin
                    n_count = r_count - CW'(1);
                end else begin
                    ram_cmd.rd_en = 1'b1;
                    ram_rd_addr   = ptr_next;
                end
            end
            prq_pkg::S_SHIFT_WR: begin
                // Move the later entry down into the gap.
                ram_cmd.wr_en = 1'b1;
                n_ptr         = ptr_next;
                n_idx         = r_idx + CW'(1);
            end
            prq_pkg::S_REPLY: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_res    = r_res;
                    n_out_count  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prq_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_handle     <= n_handle;
        r_pid        <= n_pid;
        r_ptr        <= n_ptr;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_res    <= n_out_res;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_handle = r_out_res.handle;
    assign o_result_pid    = r_out_res.pid;
    assign o_entry_count   = r_out_count;
    assign o_is_empty      = (r_out_count == '0);

endmodule

// File: rtl/core/prq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_checker: port-level checks for the process ready queue
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [prq_pkg::STATUS_W-1:0]     o_status,
    input logic [prq_pkg::HANDLE_W-1:0]     o_result_handle,
    input logic [prq_pkg::PID_W-1:0]        o_result_pid,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] o_entry_count
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // After reset the queue is idle and has no result to offer.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_result_handle)
            && $stable(o_result_pid) && $stable(o_entry_count))
        else $error("stalled result beat changed");

    // A taken request always moves the sequencer out of idle, so it blocks the next.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one still in work");

    // A full report comes only with the queue at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == prq_pkg::ST_FULL |->
            o_entry_count == CW'(QUEUE_DEPTH))
        else $error("full status below capacity");

    // Miss and full results carry no entry.
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != prq_pkg::ST_OK |->
            o_result_handle == '0 && o_result_pid == '0)
        else $error("failed operation returned an entry");

endmodule

bind process_ready_queue prq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_prq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_result_handle (o_result_handle),
    .o_result_pid    (o_result_pid),
    .o_entry_count   (o_entry_count)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the process ready queue
// A clocked driver feeds request beats from a queue of pending requests and
// predicts each reply from its own copy of the ready list; a clocked monitor
// compares every reply beat field by field. Directed corner cases come first,
// then random segments that push the list towards full or empty under changing
// idle and stall patterns, with one long hold-off on the reply side.
// ----------------------------------------------------------------------------
module testbench;

    import prq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int COUNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int RANDOM_ITEMS   = 1000;
    localparam int SEGMENT_LEN    = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_REPLY  = 40;
    localparam int DRAIN_CYCLES   = 100;

    // Highest kind code, which the queue does not act on.
    localparam logic [KIND_W-1:0] KIND_UNUSED_TOP = 3'd7;

    // Idle patterns, one per segment of the run.
    localparam int PH_STEADY     = 0;
    localparam int PH_SEND_IDLE  = 1;
    localparam int PH_RECV_STALL = 2;
    localparam int PH_BOTH       = 3;

    // Operation mixes for the random segments; any other value is a balanced mix.
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        int                  phase;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } t_reply;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind          = '0;
    logic [HANDLE_W-1:0]  i_item_handle   = '0;
    logic [PID_W-1:0]     i_process_id    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [HANDLE_W-1:0]  o_result_handle;
    logic [PID_W-1:0]     o_result_pid;
    logic [COUNT_W-1:0]   o_entry_count;
    logic                 o_is_empty;

    t_request pending_requests[$];
    t_reply   expected_replies[$];
    t_entry   ready_list[$];

    int  active_phase   = PH_STEADY;
    int  mismatch_count = 0;
    int  replies_seen   = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;

    wire request_beat = i_in_valid && !o_in_stall;
    wire reply_beat   = o_out_valid && !i_out_stall;

    process_ready_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_item_handle   (i_item_handle),
        .i_process_id    (i_process_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_result_handle (o_result_handle),
        .o_result_pid    (o_result_pid),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow ready list and returns its reply.
    function automatic t_reply apply_operation(input logic [KIND_W-1:0] kind,
                                               input logic [HANDLE_W-1:0] handle,
                                               input logic [PID_W-1:0] pid);
        t_reply r;
        t_entry e;
        int     hit;
        r   = '{status: ST_OK, handle: '0, pid: '0, count: '0, empty: 1'b0};
        hit = -1;
        case (kind)
            KIND_ENQUEUE: begin
                if (ready_list.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.handle = handle;
                    e.pid    = pid;
                    ready_list.push_back(e);
                end
            end
            KIND_DEQUEUE, KIND_PEEK: begin
                if (ready_list.size() == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.handle = ready_list[0].handle;
                    r.pid    = ready_list[0].pid;
                    if (kind == KIND_DEQUEUE) begin
                        void'(ready_list.pop_front());
                    end
                end
            end
            KIND_REMOVE: begin
                for (int i = 0; i < ready_list.size(); i++) begin
                    if (hit < 0 && ready_list[i].handle == handle) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    ready_list.delete(hit);
                end
            end
            KIND_FIND: begin
                for (int i = 0; i < ready_list.size(); i++) begin
                    if (hit < 0 && ready_list[i].pid == pid) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.handle = ready_list[hit].handle;
                    r.pid    = ready_list[hit].pid;
                end
            end
            default: begin
                // Unused kinds leave the list alone.
            end
        endcase
        r.count = COUNT_W'(ready_list.size());
        r.empty = (ready_list.size() == 0);
        return r;
    endfunction

    task automatic add_request(input logic [KIND_W-1:0] kind,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [PID_W-1:0] pid, input int phase);
        t_request q;
        q.kind   = kind;
        q.handle = handle;
        q.pid    = pid;
        q.phase  = phase;
        pending_requests.push_back(q);
    endtask

    // Request driver: holds a beat while stalled, otherwise loads the next one.
    always @(posedge i_clk) begin
        t_request q;
        logic     next_valid;
        int       idle_pct;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (request_beat) begin
                expected_replies.push_back(apply_operation(i_kind, i_item_handle,
                                                           i_process_id));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_requests.size() > 0) begin
                idle_pct = (pending_requests[0].phase == PH_SEND_IDLE) ? 80 :
                           (pending_requests[0].phase == PH_BOTH) ? 31 : 0;
                if ($urandom_range(99, 0) >= idle_pct) begin
                    q             = pending_requests.pop_front();
                    i_kind        <= q.kind;
                    i_item_handle <= q.handle;
                    i_process_id  <= q.pid;
                    active_phase  <= q.phase;
                    next_valid    = 1'b1;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Reply monitor: checks each reply beat and decides the stall for the next cycle.
    always @(posedge i_clk) begin
        t_reply e;
        int     stall_pct;
        if (i_rst_n && reply_beat) begin
            replies_seen <= replies_seen + 1;
            if (expected_replies.size() == 0) begin
                $error("reply beat with no request outstanding");
                mismatch_count++;
            end else begin
                e = expected_replies.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    mismatch_count++;
                end
                if (o_result_handle !== e.handle) begin
                    $error("result_handle: expected %0d, got %0d", e.handle,
                           o_result_handle);
                    mismatch_count++;
                end
                if (o_result_pid !== e.pid) begin
                    $error("result_pid: expected %0d, got %0d", e.pid, o_result_pid);
                    mismatch_count++;
                end
                if (o_entry_count !== e.count) begin
                    $error("entry_count: expected %0d, got %0d", e.count,
                           o_entry_count);
                    mismatch_count++;
                end
                if (o_is_empty !== e.empty) begin
                    $error("is_empty: expected %0d, got %0d", e.empty, o_is_empty);
                    mismatch_count++;
                end
            end
        end
        // One long hold-off early on, so that the queue backs up onto its input.
        if (!hold_done && replies_seen == HOLD_AT_REPLY) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_pct   = (active_phase == PH_RECV_STALL) ? 80 :
                          (active_phase == PH_BOTH) ? 31 : 0;
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (request_beat || reply_beat) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int                  seg;
        int                  mix;
        int                  phase;
        int                  roll;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;

        // Directed: operations on an empty list and an unused kind.
        add_request(KIND_PEEK, 8'd0, 15'd0, PH_STEADY);
        add_request(KIND_DEQUEUE, 8'd255, 15'd32767, PH_STEADY);
        add_request(KIND_REMOVE, 8'd0, 15'd0, PH_STEADY);
        add_request(KIND_FIND, 8'd0, 15'd0, PH_STEADY);
        add_request(KIND_UNUSED_TOP, 8'd255, 15'd32767, PH_STEADY);
        // Fill to capacity with extreme values and a duplicated handle.
        add_request(KIND_ENQUEUE, 8'd0, 15'd0, PH_STEADY);
        add_request(KIND_ENQUEUE, 8'd255, 15'd32767, PH_STEADY);
        add_request(KIND_ENQUEUE, 8'd255, 15'd1, PH_STEADY);
        for (int i = 3; i < QUEUE_DEPTH; i++) begin
            add_request(KIND_ENQUEUE, HANDLE_W'(i + 16), PID_W'(i * 100), PH_STEADY);
        end
        // Enqueue on a full list, then search and removal cases.
        add_request(KIND_ENQUEUE, 8'd77, 15'd77, PH_STEADY);
        add_request(KIND_FIND, 8'd0, 15'd32767, PH_STEADY);
        add_request(KIND_FIND, 8'd0, 15'd12345, PH_STEADY);
        add_request(KIND_REMOVE, 8'd255, 15'd0, PH_STEADY);
        add_request(KIND_REMOVE, 8'd200, 15'd0, PH_STEADY);
        add_request(KIND_PEEK, 8'd0, 15'd0, PH_STEADY);
        add_request(KIND_DEQUEUE, 8'd0, 15'd0, PH_STEADY);

        // Random segments: each has its own mix and idle pattern.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            seg   = n / SEGMENT_LEN;
            mix   = seg % 3;
            phase = seg % 4;
            roll  = $urandom_range(99, 0);
            if (roll < 5) begin
                kind = KIND_W'($urandom_range(7, 5));
            end else begin
                roll = $urandom_range(99, 0);
                case (mix)
                    MIX_FILL:  kind = (roll < 60) ? KIND_ENQUEUE :
                                      (roll < 70) ? KIND_DEQUEUE :
                                      (roll < 78) ? KIND_PEEK :
                                      (roll < 89) ? KIND_REMOVE : KIND_FIND;
                    MIX_DRAIN: kind = (roll < 15) ? KIND_ENQUEUE :
                                      (roll < 50) ? KIND_DEQUEUE :
                                      (roll < 60) ? KIND_PEEK :
                                      (roll < 85) ? KIND_REMOVE : KIND_FIND;
                    default:   kind = (roll < 35) ? KIND_ENQUEUE :
                                      (roll < 55) ? KIND_DEQUEUE :
                                      (roll < 65) ? KIND_PEEK :
                                      (roll < 83) ? KIND_REMOVE : KIND_FIND;
                endcase
            end
            // Mostly values from a small pool, so that searches hit often.
            if ($urandom_range(99, 0) < 70) begin
                handle = HANDLE_W'($urandom_range(7, 0) * 33);
                pid    = PID_W'($urandom_range(7, 0) * 4001);
            end else begin
                handle = HANDLE_W'($urandom);
                pid    = PID_W'($urandom);
            end
            add_request(kind, handle, pid, phase);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be sent and every reply to be checked.
        while (pending_requests.size() > 0 || i_in_valid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
